// File: src/tsfs_pkg.sv
package tsfs_pkg;

    // Default shape of one read group
    localparam int SAMPLES_PER_READ_DEF = 5;
    localparam int TRIM_COUNT_DEF       = 1;

    // Field widths
    localparam int SAMPLE_W = 12;
    localparam int COORD_W  = 16;
    localparam int GAIN_W   = 16;
    localparam int CFG_W    = 16;
    localparam int CFG_IDX_W = 3;

    // Calibration: Q2.14 gain
    localparam int Q_FRAC = 14;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_RAW_MODE    = 3'd0,
        CFG_X_GAIN      = 3'd1,
        CFG_X_OFFSET    = 3'd2,
        CFG_Y_GAIN      = 3'd3,
        CFG_Y_OFFSET    = 3'd4,
        CFG_AGREE_RANGE = 3'd5
    } t_cfg_idx;

    // Group within a scan: X, Y, X, Y
    typedef enum logic [1:0] {
        GRP_X1 = 2'd0,
        GRP_Y1 = 2'd1,
        GRP_X2 = 2'd2,
        GRP_Y2 = 2'd3
    } t_grp;

    // What one sort cell shows its right-hand neighbour
    typedef struct packed {
        logic [SAMPLE_W-1:0] val;
        logic                keep;
        logic                vld;
    } t_link;

    // Per-request control travelling down the pipeline
    typedef struct packed {
        logic vld;
        logic pen;
        logic clr;
        logic grp_end;
        logic scan_end;
        t_grp grp;
    } t_ctrl;

endpackage

// File: src/tsfs_cell.sv
module tsfs_cell import tsfs_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_en,
    input  logic                i_first,
    input  logic [SAMPLE_W-1:0] i_sample,
    input  t_link               i_left,
    output t_link               o_link
);

    logic [SAMPLE_W-1:0] r_val;
    logic                r_vld;
    logic [SAMPLE_W-1:0] n_val;
    logic                n_vld;
    logic                w_vld;
    logic                w_keep;

    // A new group starts with every cell empty
    assign w_vld  = r_vld && !i_first;
    assign w_keep = w_vld && (r_val <= i_sample);

    // Insertion: keep own value, take the new sample, or shift in from the left
    always_comb begin
        if (w_keep) begin
            n_val = r_val;
        end else if (i_left.keep) begin
            n_val = i_sample;
        end else begin
            n_val = i_left.val;
        end
        n_vld = w_vld || i_left.vld;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (i_en) begin
            r_vld <= n_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_val <= n_val;
        end
    end

    assign o_link = '{val: r_val, keep: w_keep, vld: w_vld};

endmodule

// File: src/tsfs_mean.sv
module tsfs_mean import tsfs_pkg::*; #(
    parameter int SAMPLES_PER_READ = SAMPLES_PER_READ_DEF,
    parameter int TRIM_COUNT       = TRIM_COUNT_DEF
) (
    input  logic                i_clk,
    input  logic                i_en,
    input  logic [SAMPLE_W-1:0] i_vals [SAMPLES_PER_READ],
    output logic [SAMPLE_W-1:0] o_mean
);

    // Trim is limited so at least one value survives
    localparam int EFF_TRIM = (2 * TRIM_COUNT < SAMPLES_PER_READ) ?
                              TRIM_COUNT : (SAMPLES_PER_READ - 1) / 2;
    localparam int KEEP     = SAMPLES_PER_READ - 2 * EFF_TRIM;
    localparam int SUM_W    = SAMPLE_W + $clog2(KEEP);
    localparam int DIV_SH   = SUM_W;
    localparam int RECIP    = (2 ** DIV_SH) / KEEP;
    localparam int PROD_W   = SUM_W + DIV_SH + 1;

    logic [SUM_W-1:0]    w_sum;
    logic [SUM_W-1:0]    r_sum;
    logic [SUM_W-1:0]    r_sum2;
    logic [PROD_W-1:0]   w_prod;
    logic [SAMPLE_W-1:0] r_q0;
    logic [SUM_W-1:0]    w_back;
    logic [SUM_W-1:0]    w_rem;
    logic [SAMPLE_W-1:0] r_mean;

    // Sum of the middle cells of the sorted row
    always_comb begin
        w_sum = '0;
        for (int i = EFF_TRIM; i < SAMPLES_PER_READ - EFF_TRIM; i++) begin
            w_sum = w_sum + SUM_W'(i_vals[i]);
        end
    end

    // Reciprocal estimate: low by at most one
    assign w_prod = PROD_W'(r_sum) * PROD_W'(RECIP);

    // Correction step
    assign w_back = SUM_W'(r_q0) * SUM_W'(KEEP);
    assign w_rem  = r_sum2 - w_back;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_sum  <= w_sum;
            r_sum2 <= r_sum;
            r_q0   <= w_prod[DIV_SH +: SAMPLE_W];
            r_mean <= (w_rem >= SUM_W'(KEEP)) ? r_q0 + 1'b1 : r_q0;
        end
    end

    assign o_mean = r_mean;

endmodule

// File: src/tsfs_cal.sv
module tsfs_cal import tsfs_pkg::*; (
    input  logic                     i_clk,
    input  logic                     i_en,
    input  logic [SAMPLE_W-1:0]      i_coord,
    input  logic signed [GAIN_W-1:0] i_gain,
    input  logic signed [GAIN_W-1:0] i_offset,
    output logic [COORD_W-1:0]       o_pos
);

    localparam int MUL_W = GAIN_W + SAMPLE_W + 1;
    localparam int ACC_W = GAIN_W + Q_FRAC + 1;
    localparam int Q_W   = ACC_W - Q_FRAC;

    logic signed [MUL_W-1:0] w_prod;
    logic signed [MUL_W-1:0] r_prod;
    logic signed [ACC_W-1:0] w_acc;
    logic signed [Q_W-1:0]   w_q;
    logic [COORD_W-1:0]      r_pos;

    // gain * coord
    assign w_prod = i_gain * $signed({1'b0, i_coord});

    // add offset in Q2.14, floor by arithmetic shift
    assign w_acc = $signed({{(ACC_W - MUL_W){r_prod[MUL_W-1]}}, r_prod})
                 + $signed({i_offset[GAIN_W-1], i_offset, {Q_FRAC{1'b0}}});
    assign w_q   = w_acc[ACC_W-1:Q_FRAC];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_prod <= w_prod;
            // negative clamps to zero; the top end cannot exceed 16 bits
            r_pos  <= w_q[Q_W-1] ? '0 : w_q[COORD_W-1:0];
        end
    end

    assign o_pos = r_pos;

endmodule

// File: src/touch_sample_filter_scan_core.sv
// Touch scan filter with trimmed-mean reads and pen tracking.
// Input channel: one request per touch ADC sample (i_pen_down, i_sample,
// i_clear_caught), taken when i_in_valid is high and o_in_stall is low.
// Output channel: o_out_valid with the coordinate fields, taken when
// i_out_stall is low. A pen-up request always yields a result; a pen-down
// request yields one only when it completes a scan of four sample groups.
// Samples are inserted into a row of sort cells as they arrive, so a group is
// sorted on its last sample; the trimmed mean, read agreement, Q2.14
// calibration and pen tracking follow in registered stages.
// Throughput: one request per cycle while no result waits on a stalled output.
// A request reaches o_out_valid through eight register stages: sort cells (1),
// mean divider (3), agreement check (1), calibration multiply and clamp (2) and
// tracker (1).
// When the output is stalled with a result waiting, the whole pipeline holds
// and o_in_stall rises; with no result waiting the pipeline keeps moving.
// Reset (synchronous, i_rst_n low) clears the scan position, coordinates,
// press point and flags and loads the register defaults; no clearing pass.
// The configuration port writes one register per cycle with i_cfg_we.
module touch_sample_filter_scan_core import tsfs_pkg::*; #(
    parameter int SAMPLES_PER_READ = SAMPLES_PER_READ_DEF,
    parameter int TRIM_COUNT       = TRIM_COUNT_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0]     i_cfg_data,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  logic                 i_pen_down,
    input  logic [SAMPLE_W-1:0]  i_sample,
    input  logic                 i_clear_caught,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output logic [COORD_W-1:0]   o_x_pos,
    output logic [COORD_W-1:0]   o_y_pos,
    output logic [COORD_W-1:0]   o_start_x,
    output logic [COORD_W-1:0]   o_start_y,
    output logic                 o_pressed,
    output logic                 o_caught_flag,
    output logic                 o_reading_ok
);

    localparam int POS_W   = $clog2(SAMPLES_PER_READ);
    localparam int C_DEPTH = 7;
    localparam int C_MEAN  = 4;

    // Configuration registers
    logic                     r_raw_mode;
    logic signed [GAIN_W-1:0] r_x_gain;
    logic signed [GAIN_W-1:0] r_x_offset;
    logic signed [GAIN_W-1:0] r_y_gain;
    logic signed [GAIN_W-1:0] r_y_offset;
    logic [SAMPLE_W-1:0]      r_agree_range;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_raw_mode    <= 1'b0;
            r_x_gain      <= GAIN_W'(1 << Q_FRAC);
            r_x_offset    <= '0;
            r_y_gain      <= GAIN_W'(1 << Q_FRAC);
            r_y_offset    <= '0;
            r_agree_range <= SAMPLE_W'(50);
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_RAW_MODE:    r_raw_mode    <= i_cfg_data[0];
                CFG_X_GAIN:      r_x_gain      <= i_cfg_data;
                CFG_X_OFFSET:    r_x_offset    <= i_cfg_data;
                CFG_Y_GAIN:      r_y_gain      <= i_cfg_data;
                CFG_Y_OFFSET:    r_y_offset    <= i_cfg_data;
                CFG_AGREE_RANGE: r_agree_range <= i_cfg_data[SAMPLE_W-1:0];
                default: ;
            endcase
        end
    end

    // Global advance: hold everything while a result waits on a stalled output
    logic r_out_vld;
    logic w_adv;
    logic w_acc;

    assign w_adv      = !(r_out_vld && i_out_stall);
    assign o_in_stall = !w_adv;
    assign w_acc      = i_in_valid && w_adv;

    // Scan position: sample within the group, and group within the scan
    logic [POS_W-1:0] r_pos;
    t_grp             r_grp;
    logic             w_last;
    t_grp             w_grp_next;

    assign w_last = (r_pos == POS_W'(SAMPLES_PER_READ - 1));

    always_comb begin
        unique case (r_grp)
            GRP_X1:  w_grp_next = GRP_Y1;
            GRP_Y1:  w_grp_next = GRP_X2;
            GRP_X2:  w_grp_next = GRP_Y2;
            GRP_Y2:  w_grp_next = GRP_X1;
            default: w_grp_next = GRP_X1;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= '0;
            r_grp <= GRP_X1;
        end else if (w_acc) begin
            if (!i_pen_down) begin
                r_pos <= '0;
                r_grp <= GRP_X1;
            end else if (w_last) begin
                r_pos <= '0;
                r_grp <= w_grp_next;
            end else begin
                r_pos <= POS_W'(r_pos + 1'b1);
            end
        end
    end

    // Row of insertion-sort cells
    t_link               w_link [SAMPLES_PER_READ+1];
    logic [SAMPLE_W-1:0] w_vals [SAMPLES_PER_READ];
    logic                w_ins;
    logic                w_first;

    assign w_ins     = w_acc && i_pen_down;
    assign w_first   = (r_pos == '0);
    assign w_link[0] = '{val: '0, keep: 1'b1, vld: 1'b1};

    genvar g;
    generate
        for (g = 0; g < SAMPLES_PER_READ; g++) begin : g_cell
            tsfs_cell u_cell (
                .i_clk    (i_clk),
                .i_rst_n  (i_rst_n),
                .i_en     (w_ins),
                .i_first  (w_first),
                .i_sample (i_sample),
                .i_left   (w_link[g]),
                .o_link   (w_link[g+1])
            );
            assign w_vals[g] = w_link[g+1].val;
        end
    endgenerate

    // Control shift line alongside the data stages
    t_ctrl r_ctrl [1:C_DEPTH];
    t_ctrl w_ctrl_in;

    assign w_ctrl_in = '{vld:      w_acc,
                         pen:      i_pen_down,
                         clr:      i_clear_caught,
                         grp_end:  i_pen_down && w_last,
                         scan_end: i_pen_down && w_last && (r_grp == GRP_Y2),
                         grp:      r_grp};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 1; k <= C_DEPTH; k++) begin
                r_ctrl[k] <= '0;
            end
        end else if (w_adv) begin
            r_ctrl[1] <= w_ctrl_in;
            for (int k = 2; k <= C_DEPTH; k++) begin
                r_ctrl[k] <= r_ctrl[k-1];
            end
        end
    end

    // Trimmed mean of the sorted group
    logic [SAMPLE_W-1:0] w_mean;

    tsfs_mean #(
        .SAMPLES_PER_READ (SAMPLES_PER_READ),
        .TRIM_COUNT       (TRIM_COUNT)
    ) u_mean (
        .i_clk  (i_clk),
        .i_en   (w_adv),
        .i_vals (w_vals),
        .o_mean (w_mean)
    );

    // Group means of the scan, and the agreement check on the last group
    logic [SAMPLE_W-1:0] r_x_first;
    logic [SAMPLE_W-1:0] r_y_first;
    logic [SAMPLE_W-1:0] r_x_second;
    logic [SAMPLE_W-1:0] w_dx;
    logic [SAMPLE_W-1:0] w_dy;
    logic [SAMPLE_W:0]   w_sx;
    logic [SAMPLE_W:0]   w_sy;
    logic                w_grp_wr;

    assign w_grp_wr = r_ctrl[C_MEAN].vld && r_ctrl[C_MEAN].grp_end;
    assign w_dx = (r_x_first > r_x_second) ? r_x_first - r_x_second
                                           : r_x_second - r_x_first;
    assign w_dy = (r_y_first > w_mean) ? r_y_first - w_mean : w_mean - r_y_first;
    assign w_sx = {1'b0, r_x_first} + {1'b0, r_x_second};
    assign w_sy = {1'b0, r_y_first} + {1'b0, w_mean};

    logic                r_ok5, r_ok6, r_ok7;
    logic [SAMPLE_W-1:0] r_mx5, r_mx6, r_mx7;
    logic [SAMPLE_W-1:0] r_my5, r_my6, r_my7;

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            if (w_grp_wr) begin
                unique case (r_ctrl[C_MEAN].grp)
                    GRP_X1:  r_x_first  <= w_mean;
                    GRP_Y1:  r_y_first  <= w_mean;
                    GRP_X2:  r_x_second <= w_mean;
                    default: ;
                endcase
            end
            r_ok5 <= (w_dx < r_agree_range) && (w_dy < r_agree_range);
            r_mx5 <= w_sx[SAMPLE_W:1];
            r_my5 <= w_sy[SAMPLE_W:1];
            r_ok6 <= r_ok5;
            r_mx6 <= r_mx5;
            r_my6 <= r_my5;
            r_ok7 <= r_ok6;
            r_mx7 <= r_mx6;
            r_my7 <= r_my6;
        end
    end

    // Calibration, one unit per axis
    logic [COORD_W-1:0] w_cal_x;
    logic [COORD_W-1:0] w_cal_y;

    tsfs_cal u_cal_x (
        .i_clk    (i_clk),
        .i_en     (w_adv),
        .i_coord  (r_mx5),
        .i_gain   (r_x_gain),
        .i_offset (r_x_offset),
        .o_pos    (w_cal_x)
    );

    tsfs_cal u_cal_y (
        .i_clk    (i_clk),
        .i_en     (w_adv),
        .i_coord  (r_my5),
        .i_gain   (r_y_gain),
        .i_offset (r_y_offset),
        .o_pos    (w_cal_y)
    );

    // Pen tracker
    logic [COORD_W-1:0] r_cur_x, r_cur_y, r_press_x, r_press_y;
    logic               r_down, r_catch, r_out_ok;
    logic [COORD_W-1:0] n_cur_x, n_cur_y, n_press_x, n_press_y;
    logic               n_down, n_catch, n_out_ok, n_out_vld;
    t_ctrl              w_c7;

    assign w_c7 = r_ctrl[C_DEPTH];

    always_comb begin
        n_cur_x   = r_cur_x;
        n_cur_y   = r_cur_y;
        n_press_x = r_press_x;
        n_press_y = r_press_y;
        n_down    = r_down;
        n_catch   = r_catch;
        n_out_ok  = w_c7.vld && w_c7.pen && w_c7.scan_end && r_ok7;
        n_out_vld = w_c7.vld && (!w_c7.pen || w_c7.scan_end);
        if (w_c7.vld) begin
            if (w_c7.clr) begin
                n_catch = 1'b0;
            end
            if (w_c7.pen) begin
                if (w_c7.scan_end) begin
                    // failed reads keep the old coordinates
                    if (r_ok7) begin
                        n_cur_x = r_raw_mode ? COORD_W'(r_mx7) : w_cal_x;
                        n_cur_y = r_raw_mode ? COORD_W'(r_my7) : w_cal_y;
                    end
                    if (!r_down) begin
                        n_down    = 1'b1;
                        n_catch   = 1'b1;
                        n_press_x = n_cur_x;
                        n_press_y = n_cur_y;
                    end
                end
            end else if (r_down) begin
                n_down = 1'b0;
            end else begin
                // idle and released
                n_press_x = '0;
                n_press_y = '0;
                n_cur_x   = '1;
                n_cur_y   = '1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur_x   <= '0;
            r_cur_y   <= '0;
            r_press_x <= '0;
            r_press_y <= '0;
            r_down    <= 1'b0;
            r_catch   <= 1'b0;
            r_out_ok  <= 1'b0;
            r_out_vld <= 1'b0;
        end else if (w_adv) begin
            r_cur_x   <= n_cur_x;
            r_cur_y   <= n_cur_y;
            r_press_x <= n_press_x;
            r_press_y <= n_press_y;
            r_down    <= n_down;
            r_catch   <= n_catch;
            r_out_ok  <= n_out_ok;
            r_out_vld <= n_out_vld;
        end
    end

    // Tracker state only moves when the output is free, so it doubles as the result
    assign o_out_valid   = r_out_vld;
    assign o_x_pos       = r_cur_x;
    assign o_y_pos       = r_cur_y;
    assign o_start_x     = r_press_x;
    assign o_start_y     = r_press_y;
    assign o_pressed     = r_down;
    assign o_caught_flag = r_catch;
    assign o_reading_ok  = r_out_ok;

endmodule

// File: bench/tsfs_scan_checker.sv
module tsfs_scan_checker import tsfs_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0]    i_cfg_data,
    input  logic                i_in_valid,
    input  logic                i_in_stall,
    input  logic                i_pen_down,
    input  logic [SAMPLE_W-1:0] i_sample,
    input  logic                i_clear_caught,
    input  logic                i_out_valid,
    input  logic                i_out_stall,
    input  logic [COORD_W-1:0]  i_x_pos,
    input  logic [COORD_W-1:0]  i_y_pos,
    input  logic [COORD_W-1:0]  i_start_x,
    input  logic [COORD_W-1:0]  i_start_y,
    input  logic                i_pressed,
    input  logic                i_caught_flag,
    input  logic                i_reading_ok,
    output int                  o_fail_count,
    output int                  o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int SPR       = SAMPLES_PER_READ_DEF;
    localparam int TRIM      = TRIM_COUNT_DEF;
    localparam int SCAN_LEN  = 4 * SPR;
    localparam int EFF_TRIM  = (2 * TRIM < SPR) ? TRIM : (SPR - 1) / 2;
    localparam int COORD_MAX = (1 << COORD_W) - 1;

    // One touch report as the block presents it
    typedef struct packed {
        logic [COORD_W-1:0] x_pos;
        logic [COORD_W-1:0] y_pos;
        logic [COORD_W-1:0] start_x;
        logic [COORD_W-1:0] start_y;
        logic               pressed;
        logic               caught;
        logic               ok;
    } t_touch_report;

    // Register copy
    logic                     raw_mode;
    logic signed [GAIN_W-1:0] x_gain, x_offset, y_gain, y_offset;
    logic [SAMPLE_W-1:0]      agree_lim;

    // Scan and pen state
    logic [SAMPLE_W-1:0] grp_buf [SPR];
    int unsigned         scan_slot;
    logic [SAMPLE_W-1:0] x_first, y_first, x_second;
    logic [COORD_W-1:0]  cur_x, cur_y, press_x, press_y;
    logic                pen_held, caught;

    t_touch_report touch_reports_due [$];
    int            mismatches = 0;

    // Sort the group, drop the trimmed ends, truncating mean of the rest
    function automatic logic [SAMPLE_W-1:0] trimmed_mean();
        logic [SAMPLE_W-1:0] srt [SPR];
        logic [SAMPLE_W-1:0] t;
        int unsigned         acc;
        srt = grp_buf;
        for (int i = 0; i < SPR - 1; i++)
            for (int j = i + 1; j < SPR; j++)
                if (srt[i] > srt[j]) begin
                    t = srt[i];
                    srt[i] = srt[j];
                    srt[j] = t;
                end
        acc = 0;
        for (int i = EFF_TRIM; i < SPR - EFF_TRIM; i++)
            acc += srt[i];
        return SAMPLE_W'(acc / (SPR - 2 * EFF_TRIM));
    endfunction

    function automatic bit reads_agree(logic [SAMPLE_W-1:0] a, logic [SAMPLE_W-1:0] b);
        logic [SAMPLE_W-1:0] d;
        d = (a > b) ? a - b : b - a;
        return d < agree_lim;
    endfunction

    // Q2.14 gain plus pixel offset, floored, clamped to the coordinate range
    function automatic logic [COORD_W-1:0] to_screen(logic [SAMPLE_W-1:0] c,
                                                     logic signed [GAIN_W-1:0] gain,
                                                     logic signed [GAIN_W-1:0] offset);
        longint v;
        longint q;
        v = longint'(gain) * longint'(c) + (longint'(offset) <<< Q_FRAC);
        q = v >>> Q_FRAC;
        if (q < 0)
            return '0;
        if (q > COORD_MAX)
            return COORD_W'(COORD_MAX);
        return COORD_W'(q);
    endfunction

    // Advance the scan by one request; returns 1 when it yields a report
    function automatic bit advance_scan(bit pen, logic [SAMPLE_W-1:0] smp, bit clr,
                                        output t_touch_report rep);
        int unsigned         slot, pos, grp;
        logic [SAMPLE_W-1:0] y_second, mx, my;
        bit                  ok;
        ok = 1'b0;
        if (clr)
            caught = 1'b0;
        if (pen) begin
            slot = (scan_slot < SCAN_LEN) ? scan_slot : 0;
            pos  = slot % SPR;
            grp  = slot / SPR;
            grp_buf[pos] = smp;
            scan_slot = slot + 1;
            if (pos != SPR - 1)
                return 1'b0;
            case (t_grp'(grp[1:0]))
                GRP_X1: begin
                    x_first = trimmed_mean();
                    return 1'b0;
                end
                GRP_Y1: begin
                    y_first = trimmed_mean();
                    return 1'b0;
                end
                GRP_X2: begin
                    x_second = trimmed_mean();
                    return 1'b0;
                end
                default: begin
                    y_second  = trimmed_mean();
                    scan_slot = 0;
                    if (reads_agree(x_first, x_second) && reads_agree(y_first, y_second)) begin
                        mx = SAMPLE_W'((int'(x_first) + int'(x_second)) >> 1);
                        my = SAMPLE_W'((int'(y_first) + int'(y_second)) >> 1);
                        ok = 1'b1;
                        if (raw_mode) begin
                            cur_x = COORD_W'(mx);
                            cur_y = COORD_W'(my);
                        end else begin
                            cur_x = to_screen(mx, x_gain, x_offset);
                            cur_y = to_screen(my, y_gain, y_offset);
                        end
                    end
                    // first completed scan of a press latches the start point
                    if (!pen_held) begin
                        pen_held = 1'b1;
                        caught   = 1'b1;
                        press_x  = cur_x;
                        press_y  = cur_y;
                    end
                end
            endcase
        end else begin
            scan_slot = 0;
            if (pen_held) begin
                pen_held = 1'b0;
            end else begin
                press_x = '0;
                press_y = '0;
                cur_x   = '1;
                cur_y   = '1;
            end
        end
        rep = '{cur_x, cur_y, press_x, press_y, pen_held, caught, ok};
        return 1'b1;
    endfunction

    function automatic int field_differs(string name, int want, int got);
        if (want == got)
            return 0;
        $error("%s: expected %0d, got %0d", name, want, got);
        return 1;
    endfunction

    always @(posedge i_clk) begin
        t_touch_report want, got;
        if (!i_rst_n) begin
            raw_mode  = 1'b0;
            x_gain    = GAIN_W'(1 << Q_FRAC);
            x_offset  = '0;
            y_gain    = GAIN_W'(1 << Q_FRAC);
            y_offset  = '0;
            agree_lim = SAMPLE_W'(50);
            foreach (grp_buf[i])
                grp_buf[i] = '0;
            scan_slot = 0;
            x_first   = '0;
            y_first   = '0;
            x_second  = '0;
            cur_x     = '0;
            cur_y     = '0;
            press_x   = '0;
            press_y   = '0;
            pen_held  = 1'b0;
            caught    = 1'b0;
            touch_reports_due.delete();
        end else begin
            // register writes
            if (i_cfg_we) begin
                case (t_cfg_idx'(i_cfg_idx))
                    CFG_RAW_MODE:    raw_mode  = i_cfg_data[0];
                    CFG_X_GAIN:      x_gain    = i_cfg_data;
                    CFG_X_OFFSET:    x_offset  = i_cfg_data;
                    CFG_Y_GAIN:      y_gain    = i_cfg_data;
                    CFG_Y_OFFSET:    y_offset  = i_cfg_data;
                    CFG_AGREE_RANGE: agree_lim = i_cfg_data[SAMPLE_W-1:0];
                    default: ;
                endcase
            end

            // compare an accepted report with the oldest one due
            if (i_out_valid && !i_out_stall) begin
                got = '{i_x_pos, i_y_pos, i_start_x, i_start_y,
                        i_pressed, i_caught_flag, i_reading_ok};
                if (touch_reports_due.size() == 0) begin
                    $error("report with none due: x_pos %0d y_pos %0d", got.x_pos, got.y_pos);
                    mismatches++;
                end else begin
                    want = touch_reports_due.pop_front();
                    mismatches += field_differs("x_pos", want.x_pos, got.x_pos);
                    mismatches += field_differs("y_pos", want.y_pos, got.y_pos);
                    mismatches += field_differs("start_x", want.start_x, got.start_x);
                    mismatches += field_differs("start_y", want.start_y, got.start_y);
                    mismatches += field_differs("pressed", want.pressed, got.pressed);
                    mismatches += field_differs("caught_flag", want.caught, got.caught);
                    mismatches += field_differs("reading_ok", want.ok, got.ok);
                end
            end

            // predict from an accepted request
            if (i_in_valid && !i_in_stall)
                if (advance_scan(i_pen_down, i_sample, i_clear_caught, want))
                    touch_reports_due.push_back(want);
        end
        o_pending    <= touch_reports_due.size();
        o_fail_count <= mismatches;
    end

endmodule

// File: bench/tb_top.sv
module tb_top import tsfs_pkg::*; ();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int SPR         = SAMPLES_PER_READ_DEF;
    localparam int SCAN_LEN    = 4 * SPR;
    localparam int SETTLE      = 16;
    localparam int LONG_HOLD   = 80;
    localparam int CYCLE_LIMIT = 200000;

    typedef enum int {RX_FREE, RX_LIGHT, RX_HEAVY, RX_TOGGLE} t_rx_mode;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_idx = '0;
    logic [CFG_W-1:0]     cfg_data = '0;
    logic                 in_valid = 1'b0;
    logic                 pen_down = 1'b0;
    logic [SAMPLE_W-1:0]  sample = '0;
    logic                 clear_caught = 1'b0;
    logic                 out_stall = 1'b0;
    logic                 in_stall, out_valid;
    logic [COORD_W-1:0]   x_pos, y_pos, start_x, start_y;
    logic                 pressed, caught_flag, reading_ok;
    int                   fail_count, pending;

    int       sent = 0;
    int       burst_left = 0;
    bit       pace_on = 1'b1;
    int       hold_reqs = 0;
    int       hold_seen = 0;
    int       hold_left = 0;
    int       mode_left = 0;
    t_rx_mode rx_mode = RX_FREE;
    int       cycles = 0;

    touch_sample_filter_scan_core u_dut (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_cfg_we       (cfg_we),
        .i_cfg_idx      (cfg_idx),
        .i_cfg_data     (cfg_data),
        .i_in_valid     (in_valid),
        .o_in_stall     (in_stall),
        .i_pen_down     (pen_down),
        .i_sample       (sample),
        .i_clear_caught (clear_caught),
        .o_out_valid    (out_valid),
        .i_out_stall    (out_stall),
        .o_x_pos        (x_pos),
        .o_y_pos        (y_pos),
        .o_start_x      (start_x),
        .o_start_y      (start_y),
        .o_pressed      (pressed),
        .o_caught_flag  (caught_flag),
        .o_reading_ok   (reading_ok)
    );

    tsfs_scan_checker u_check (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_cfg_we       (cfg_we),
        .i_cfg_idx      (cfg_idx),
        .i_cfg_data     (cfg_data),
        .i_in_valid     (in_valid),
        .i_in_stall     (in_stall),
        .i_pen_down     (pen_down),
        .i_sample       (sample),
        .i_clear_caught (clear_caught),
        .i_out_valid    (out_valid),
        .i_out_stall    (out_stall),
        .i_x_pos        (x_pos),
        .i_y_pos        (y_pos),
        .i_start_x      (start_x),
        .i_start_y      (start_y),
        .i_pressed      (pressed),
        .i_caught_flag  (caught_flag),
        .i_reading_ok   (reading_ok),
        .o_fail_count   (fail_count),
        .o_pending      (pending)
    );

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Watchdog
    always @(posedge clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("tb_top failed");
            $finish;
        end
    end

    // Receiver: long hold-off on request, otherwise a changing stall pattern
    always @(posedge clk) begin
        if (hold_left > 0) begin
            out_stall <= 1'b1;
            hold_left--;
        end else if (hold_seen != hold_reqs) begin
            hold_seen = hold_reqs;
            hold_left = LONG_HOLD - 1;
            out_stall <= 1'b1;
        end else begin
            if (mode_left == 0) begin
                rx_mode   = t_rx_mode'($urandom_range(0, 3));
                mode_left = $urandom_range(10, 60);
            end
            mode_left--;
            case (rx_mode)
                RX_FREE:   out_stall <= 1'b0;
                RX_LIGHT:  out_stall <= ($urandom_range(0, 3) == 0);
                RX_HEAVY:  out_stall <= ($urandom_range(0, 3) != 0);
                RX_TOGGLE: out_stall <= ~out_stall;
                default:   out_stall <= 1'b0;
            endcase
        end
    end

    // Sender pacing: bursts of random length, random gaps between them
    task automatic pace();
        int gap;
        if (!pace_on)
            return;
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            gap = $urandom_range(1, 6);
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 40)
                                                     : $urandom_range(0, 8);
        end
    endtask

    // Offer one request and wait until it is taken
    task automatic send_req(bit pen, logic [SAMPLE_W-1:0] smp, bit clr);
        in_valid     <= 1'b1;
        pen_down     <= pen;
        sample       <= smp;
        clear_caught <= clr;
        do @(posedge clk); while (in_stall);
        sent++;
        pace();
    endtask

    // Stop sending and let every due report come out
    task automatic settle();
        in_valid <= 1'b0;
        do @(posedge clk); while (pending != 0);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_reg(t_cfg_idx idx, logic [CFG_W-1:0] data);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= data;
        @(posedge clk);
    endtask

    task automatic program_regs(bit raw, logic [15:0] xg, logic [15:0] xo,
                                logic [15:0] yg, logic [15:0] yo,
                                logic [SAMPLE_W-1:0] agree_lim);
        write_reg(CFG_RAW_MODE, CFG_W'(raw));
        write_reg(CFG_X_GAIN, xg);
        write_reg(CFG_X_OFFSET, xo);
        write_reg(CFG_Y_GAIN, yg);
        write_reg(CFG_Y_OFFSET, yo);
        write_reg(CFG_AGREE_RANGE, CFG_W'(agree_lim));
        cfg_we <= 1'b0;
    endtask

    // Sample around a base; now and then a wild outlier
    function automatic logic [SAMPLE_W-1:0] jitter(int base, int spread);
        int v;
        if ($urandom_range(0, 11) == 0)
            return SAMPLE_W'($urandom);
        v = base + int'($urandom_range(0, 2 * spread)) - spread;
        if (v < 0)
            v = 0;
        if (v > 4095)
            v = 4095;
        return SAMPLE_W'(v);
    endfunction

    function automatic int pick_base();
        case ($urandom_range(0, 9))
            0:       return 0;
            1:       return 4095;
            default: return $urandom_range(0, 4095);
        endcase
    endfunction

    function automatic int pick_spread();
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4: return $urandom_range(0, 10);
            5, 6, 7:       return $urandom_range(0, 40);
            8:             return 200;
            default:       return 2048;
        endcase
    endfunction

    // Pen-down requests: X, Y, X, Y groups; len below a full scan breaks it off
    task automatic pen_scan(int bx, int by, int spread, int len);
        for (int i = 0; i < len; i++)
            send_req(1'b1, jitter(((i / SPR) % 2 == 0) ? bx : by, spread),
                     $urandom_range(0, 5) == 0);
    endtask

    task automatic release_pen(int n);
        repeat (n) send_req(1'b0, SAMPLE_W'($urandom), $urandom_range(0, 3) == 0);
    endtask

    // Mostly presses with whole scans, some broken scans, some noise
    task automatic run_phase(int n);
        int first, act, bx, by, spread;
        first = sent;
        while (sent - first < n) begin
            act    = $urandom_range(0, 99);
            bx     = pick_base();
            by     = pick_base();
            spread = pick_spread();
            if (act < 65) begin
                repeat ($urandom_range(1, 3)) pen_scan(bx, by, spread, SCAN_LEN);
                release_pen($urandom_range(1, 2));
            end else if (act < 80) begin
                pen_scan(bx, by, spread, $urandom_range(1, SCAN_LEN - 1));
                release_pen(1);
            end else begin
                repeat ($urandom_range(1, 6))
                    send_req(1'($urandom_range(0, 1)), SAMPLE_W'($urandom),
                             $urandom_range(0, 3) == 0);
            end
        end
    endtask

    initial begin
        logic [SAMPLE_W-1:0] s;
        int                  pos;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: release while idle, one press with extreme samples, release twice
        send_req(1'b0, 12'hFFF, 1'b1);
        for (int i = 0; i < SCAN_LEN; i++) begin
            pos = i % SPR;
            if ((i / SPR) % 2 == 0)
                s = (pos == 0) ? 12'd4095 : (pos == 1) ? 12'd0 : 12'd100;
            else
                s = (pos == SPR - 1) ? 12'd0 : (pos == SPR - 2) ? 12'd4094 : 12'd4095;
            send_req(1'b1, s, i == SCAN_LEN - 1);
        end
        send_req(1'b0, 12'h000, 1'b1);
        send_req(1'b0, 12'h555, 1'b0);
        settle();

        // Raw coordinates, widest agreement window
        program_regs(1'b1, 16'h4000, 16'h0000, 16'h4000, 16'h0000, 12'd4095);
        run_phase(35);
        settle();

        // Largest gains; offsets at both extremes
        program_regs(1'b0, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h8000, 12'd200);
        run_phase(30);
        settle();

        // Most negative gains, narrowest non-zero window
        program_regs(1'b0, 16'h8000, 16'h8000, 16'h8000, 16'h7FFF, 12'd1);
        run_phase(30);
        settle();

        // Output held off while releases pour in, so the block backs up
        program_regs(1'b0, 16'($urandom_range(8000, 24000)), 16'($urandom_range(0, 1000) - 500),
                     16'($urandom_range(8000, 24000)), 16'($urandom_range(0, 1000) - 500),
                     12'($urandom_range(1, 120)));
        hold_reqs <= hold_reqs + 1;
        pace_on = 1'b0;
        release_pen(30);
        pace_on = 1'b1;
        run_phase(25);
        settle();

        // Zero window: no scan ever agrees
        program_regs(1'b0, 16'h4000, 16'h0000, 16'h4000, 16'h0000, 12'd0);
        run_phase(20);
        settle();

        program_regs(1'b0, 16'($urandom_range(8000, 24000)), 16'($urandom_range(0, 1000) - 500),
                     16'($urandom_range(8000, 24000)), 16'($urandom_range(0, 1000) - 500),
                     12'($urandom_range(1, 120)));
        run_phase(30);
        settle();

        program_regs(1'($urandom_range(0, 1)), 16'($urandom), 16'($urandom),
                     16'($urandom), 16'($urandom), 12'($urandom));
        run_phase(30);
        settle();

        if (fail_count == 0)
            $display("tb_top passed");
        else
            $display("tb_top failed");
        $finish;
    end

endmodule

// File: touch_sample_filter_scan_core.f
src/tsfs_pkg.sv
src/tsfs_cell.sv
src/tsfs_mean.sv
src/tsfs_cal.sv
src/touch_sample_filter_scan_core.sv
bench/tsfs_scan_checker.sv
bench/tb_top.sv
